>>> rtl/core/lps_pkg.sv
// Shared types, widths and codes for the localization phase supervisor.
// No dependencies; every other file of the block refers to it by scoped names.
package lps_pkg;

  localparam int FUNC_W  = 2;
  localparam int POS_W   = 24;
  localparam int HEAD_W  = 16;
  localparam int CNT_W   = 8;
  localparam int DIST_W  = 23;
  localparam int CODE_W  = 2;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;

  // Difference of two positions, its magnitude and square widths.
  localparam int DIFF_W  = POS_W + 1;
  localparam int SQ_W    = 2 * DIFF_W;
  localparam int SUM_W   = SQ_W + 1;
  localparam int LIM_W   = 2 * DIST_W;

  // Event kinds.
  localparam logic [FUNC_W-1:0] FUNC_POSE  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_MATCH = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_FORCE = 2'd2;

  // Phase codes as shown on the result channel.
  localparam logic [CODE_W-1:0] PHASE_SEARCH = 2'd0;
  localparam logic [CODE_W-1:0] PHASE_WAIT   = 2'd1;
  localparam logic [CODE_W-1:0] PHASE_TRACK  = 2'd2;

  // Coarse localizer commands.
  localparam logic [CODE_W-1:0] ACT_NONE    = 2'd0;
  localparam logic [CODE_W-1:0] ACT_ENABLE  = 2'd1;
  localparam logic [CODE_W-1:0] ACT_DISABLE = 2'd2;

  // Register indexes (paddr[3:2]).
  localparam logic [1:0] REG_POSE_TARGET  = 2'd0;
  localparam logic [1:0] REG_MAX_DISTANCE = 2'd1;
  localparam logic [1:0] REG_MAX_HEADING  = 2'd2;
  localparam logic [1:0] REG_FAIL_LIMIT   = 2'd3;

  // Register reset values.
  localparam logic [CNT_W-1:0]  RST_POSE_TARGET  = 8'd3;
  localparam logic [DIST_W-1:0] RST_MAX_DISTANCE = 23'd256;
  localparam logic [HEAD_W-1:0] RST_MAX_HEADING  = 16'd1820;
  localparam logic [CNT_W-1:0]  RST_FAIL_LIMIT   = 8'd3;
  localparam logic [LIM_W-1:0]  RST_DIST_SQ      = 46'd65536;

  typedef enum logic [2:0] {
    ST_SEARCH = 3'b001,
    ST_WAIT   = 3'b010,
    ST_TRACK  = 3'b100
  } phase_t;

  typedef struct packed {
    logic [CNT_W-1:0]  pose_count_target;
    logic [LIM_W-1:0]  dist_sq;
    logic [HEAD_W-1:0] max_heading_diff;
    logic [CNT_W-1:0]  failure_limit;
  } lps_cfg_t;

  function automatic logic [CODE_W-1:0] phase_code(phase_t ph);
    logic [CODE_W-1:0] code;
    unique case (ph)
      ST_SEARCH: code = PHASE_SEARCH;
      ST_WAIT:   code = PHASE_WAIT;
      default:   code = PHASE_TRACK;
    endcase
    return code;
  endfunction

endpackage

>>> rtl/core/lps_if.sv
// Valid/ready channel interfaces for events in and status results out.
// Depends on lps_pkg for field widths.
interface lps_in_if;
  logic                              valid;
  logic                              ready;
  logic [lps_pkg::FUNC_W-1:0]        func;
  logic signed [lps_pkg::POS_W-1:0]  pos_x;
  logic signed [lps_pkg::POS_W-1:0]  pos_y;
  logic [lps_pkg::HEAD_W-1:0]        heading;
  logic                              pose_valid;
  logic                              match_accepted;

  modport source(output valid, func, pos_x, pos_y, heading, pose_valid, match_accepted,
                 input ready);
  modport sink(input valid, func, pos_x, pos_y, heading, pose_valid, match_accepted,
               output ready);
endinterface

interface lps_out_if;
  logic                        valid;
  logic                        ready;
  logic [lps_pkg::CODE_W-1:0]  phase;
  logic [lps_pkg::CODE_W-1:0]  action;
  logic                        pose_accepted;
  logic [lps_pkg::CNT_W-1:0]   consistent_count;
  logic [lps_pkg::CNT_W-1:0]   failure_count;

  modport source(output valid, phase, action, pose_accepted, consistent_count,
                 failure_count, input ready);
  modport sink(input valid, phase, action, pose_accepted, consistent_count,
               failure_count, output ready);
endinterface

>>> rtl/core/localization_phase_supervisor.sv
// Localization phase supervisor (searching, waiting, tracking); uses lps_pkg, lps_if,
// lps_cfg_regs and lps_match.
// An accepted transaction passes the input stage, then the result register, to reach status.
// Throughput: one per cycle unless status stalls; the match and phase logic are combinational.
// A stalled status holds its register; the input stage takes one more transaction.
// Reset (rst, sync, active high): searching, anchor and counters cleared, registers 3/256/1820/3.
module localization_phase_supervisor (
  input  logic                        clk,
  input  logic                        rst,
  lps_in_if.sink                      pose,
  lps_out_if.source                   status,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lps_pkg::ADDR_W-1:0]  paddr,
  input  logic [lps_pkg::DATA_W-1:0]  pwdata,
  output logic [lps_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  lps_pkg::lps_cfg_t cfg;

  // Input register stage.
  logic                              s1_valid;
  logic [lps_pkg::FUNC_W-1:0]        s1_func;
  logic signed [lps_pkg::POS_W-1:0]  s1_pos_x;
  logic signed [lps_pkg::POS_W-1:0]  s1_pos_y;
  logic [lps_pkg::HEAD_W-1:0]        s1_heading;
  logic                              s1_pose_valid;
  logic                              s1_match_accepted;

  // Supervisor state.
  lps_pkg::phase_t                   phase, phase_next;
  logic                              anchor_valid, anchor_valid_next;
  logic signed [lps_pkg::POS_W-1:0]  anchor_x;
  logic signed [lps_pkg::POS_W-1:0]  anchor_y;
  logic [lps_pkg::HEAD_W-1:0]        anchor_heading;
  logic                              anchor_load;
  logic [lps_pkg::CNT_W-1:0]         cons_cnt, cons_cnt_next;
  logic [lps_pkg::CNT_W-1:0]         fail_cnt, fail_cnt_next;

  // Result register.
  logic                              out_valid;
  logic [lps_pkg::CODE_W-1:0]        out_phase;
  logic [lps_pkg::CODE_W-1:0]        out_action, action_next;
  logic                              out_accepted, accepted_next;
  logic [lps_pkg::CNT_W-1:0]         out_cons;
  logic [lps_pkg::CNT_W-1:0]         out_fail;

  logic                              advance;
  logic                              fire;
  logic                              hit;

  lps_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lps_match u_match (
    .pos_x          (s1_pos_x),
    .pos_y          (s1_pos_y),
    .heading        (s1_heading),
    .anchor_x       (anchor_x),
    .anchor_y       (anchor_y),
    .anchor_heading (anchor_heading),
    .cfg            (cfg),
    .hit            (hit)
  );

  // Advance the result register when it is empty or being drained; the input
  // stage refills in the same cycle, so transactions stream one per cycle unless status stalls.
  assign advance    = !out_valid || status.ready;
  assign fire       = s1_valid && advance;
  assign pose.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (pose.ready) begin
      s1_valid <= pose.valid;
    end
  end

  // Payload of the input stage needs no reset.
  always_ff @(posedge clk) begin
    if (pose.ready && pose.valid) begin
      s1_func           <= pose.func;
      s1_pos_x          <= pose.pos_x;
      s1_pos_y          <= pose.pos_y;
      s1_heading        <= pose.heading;
      s1_pose_valid     <= pose.pose_valid;
      s1_match_accepted <= pose.match_accepted;
    end
  end

  // Event handling for the transaction in the input stage.
  always_comb begin
    logic [lps_pkg::CNT_W-1:0] cons_tmp;
    logic [lps_pkg::CNT_W-1:0] fail_tmp;

    phase_next        = phase;
    anchor_valid_next = anchor_valid;
    anchor_load       = 1'b0;
    cons_cnt_next     = cons_cnt;
    fail_cnt_next     = fail_cnt;
    action_next       = lps_pkg::ACT_NONE;
    accepted_next     = 1'b0;
    cons_tmp          = cons_cnt;
    fail_tmp          = fail_cnt;

    unique case (s1_func)
      lps_pkg::FUNC_POSE: begin
        // Coarse poses count only while searching.
        if (phase == lps_pkg::ST_SEARCH && s1_pose_valid) begin
          if (anchor_valid && hit) begin
            cons_tmp = (cons_cnt == '1) ? cons_cnt : cons_cnt + 1'b1;
          end else begin
            // Replace the anchor and restart the count at one.
            anchor_valid_next = 1'b1;
            anchor_load       = 1'b1;
            cons_tmp          = {{(lps_pkg::CNT_W-1){1'b0}}, 1'b1};
          end
          cons_cnt_next = cons_tmp;
          if (cons_tmp >= cfg.pose_count_target) begin
            phase_next    = lps_pkg::ST_WAIT;
            fail_cnt_next = '0;
            accepted_next = 1'b1;
          end
        end
      end
      lps_pkg::FUNC_MATCH: begin
        if (phase != lps_pkg::ST_SEARCH) begin
          if (s1_match_accepted) begin
            fail_cnt_next = '0;
            if (phase == lps_pkg::ST_WAIT) begin
              phase_next  = lps_pkg::ST_TRACK;
              action_next = lps_pkg::ACT_DISABLE;
            end
          end else begin
            fail_tmp      = (fail_cnt == '1) ? fail_cnt : fail_cnt + 1'b1;
            fail_cnt_next = fail_tmp;
            // Too many rejects: drop the anchor and relocalize.
            if (fail_tmp >= cfg.failure_limit) begin
              phase_next        = lps_pkg::ST_SEARCH;
              fail_cnt_next     = '0;
              anchor_valid_next = 1'b0;
              cons_cnt_next     = '0;
              action_next       = lps_pkg::ACT_ENABLE;
            end
          end
        end
      end
      lps_pkg::FUNC_FORCE: begin
        phase_next        = lps_pkg::ST_SEARCH;
        fail_cnt_next     = '0;
        anchor_valid_next = 1'b0;
        cons_cnt_next     = '0;
      end
      default: begin
        // Undefined event kind: hold state, report it unchanged.
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= lps_pkg::ST_SEARCH;
      anchor_valid <= 1'b0;
      cons_cnt     <= '0;
      fail_cnt     <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (fire) begin
        phase        <= phase_next;
        anchor_valid <= anchor_valid_next;
        cons_cnt     <= cons_cnt_next;
        fail_cnt     <= fail_cnt_next;
      end
      if (advance) begin
        out_valid <= s1_valid;
      end
    end
  end

  // Anchor coordinates are only read while anchor_valid is set.
  always_ff @(posedge clk) begin
    if (fire && anchor_load) begin
      anchor_x       <= s1_pos_x;
      anchor_y       <= s1_pos_y;
      anchor_heading <= s1_heading;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_phase    <= lps_pkg::phase_code(phase_next);
      out_action   <= action_next;
      out_accepted <= accepted_next;
      out_cons     <= cons_cnt_next;
      out_fail     <= fail_cnt_next;
    end
  end

  assign status.valid            = out_valid;
  assign status.phase            = out_phase;
  assign status.action           = out_action;
  assign status.pose_accepted    = out_accepted;
  assign status.consistent_count = out_cons;
  assign status.failure_count    = out_fail;

endmodule

>>> rtl/core/lps_cfg_regs.sv
// APB-style configuration registers plus the registered squared distance limit.
// Depends on lps_pkg.
module lps_cfg_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lps_pkg::ADDR_W-1:0]  paddr,
  input  logic [lps_pkg::DATA_W-1:0]  pwdata,
  output logic [lps_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output lps_pkg::lps_cfg_t           cfg
);

  logic [lps_pkg::CNT_W-1:0]  pose_count_target;
  logic [lps_pkg::DIST_W-1:0] max_distance;
  logic [lps_pkg::HEAD_W-1:0] max_heading_diff;
  logic [lps_pkg::CNT_W-1:0]  failure_limit;
  logic [lps_pkg::LIM_W-1:0]  dist_sq;
  logic                       wr_en;
  logic [1:0]                 reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      pose_count_target <= lps_pkg::RST_POSE_TARGET;
      max_distance      <= lps_pkg::RST_MAX_DISTANCE;
      max_heading_diff  <= lps_pkg::RST_MAX_HEADING;
      failure_limit     <= lps_pkg::RST_FAIL_LIMIT;
      dist_sq           <= lps_pkg::RST_DIST_SQ;
    end else begin
      // Registered square of max_distance; writes must only happen while idle, not enforced by the block.
      dist_sq <= max_distance * max_distance;
      if (wr_en) begin
        unique case (reg_idx)
          lps_pkg::REG_POSE_TARGET:  pose_count_target <= pwdata[lps_pkg::CNT_W-1:0];
          lps_pkg::REG_MAX_DISTANCE: max_distance      <= pwdata[lps_pkg::DIST_W-1:0];
          lps_pkg::REG_MAX_HEADING:  max_heading_diff  <= pwdata[lps_pkg::HEAD_W-1:0];
          default:                   failure_limit     <= pwdata[lps_pkg::CNT_W-1:0];
        endcase
      end
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      lps_pkg::REG_POSE_TARGET:  prdata[lps_pkg::CNT_W-1:0]  = pose_count_target;
      lps_pkg::REG_MAX_DISTANCE: prdata[lps_pkg::DIST_W-1:0] = max_distance;
      lps_pkg::REG_MAX_HEADING:  prdata[lps_pkg::HEAD_W-1:0] = max_heading_diff;
      default:                   prdata[lps_pkg::CNT_W-1:0]  = failure_limit;
    endcase
  end

  assign cfg.pose_count_target = pose_count_target;
  assign cfg.dist_sq           = dist_sq;
  assign cfg.max_heading_diff  = max_heading_diff;
  assign cfg.failure_limit     = failure_limit;

endmodule

>>> rtl/core/lps_match.sv
// Pose-to-anchor match test: squared distance and wrapped heading difference.
// Depends on lps_pkg.
module lps_match (
  input  logic signed [lps_pkg::POS_W-1:0] pos_x,
  input  logic signed [lps_pkg::POS_W-1:0] pos_y,
  input  logic [lps_pkg::HEAD_W-1:0]       heading,
  input  logic signed [lps_pkg::POS_W-1:0] anchor_x,
  input  logic signed [lps_pkg::POS_W-1:0] anchor_y,
  input  logic [lps_pkg::HEAD_W-1:0]       anchor_heading,
  input  lps_pkg::lps_cfg_t                cfg,
  output logic                             hit
);

  logic signed [lps_pkg::DIFF_W-1:0] dx, dy;
  logic [lps_pkg::DIFF_W-1:0]        adx, ady;
  logic [lps_pkg::SQ_W-1:0]          sqx, sqy;
  logic [lps_pkg::SUM_W-1:0]         dist2;
  logic [lps_pkg::HEAD_W-1:0]        dh;
  logic [lps_pkg::HEAD_W:0]          adh;
  logic                              near_pos, near_head;

  assign dx  = {pos_x[lps_pkg::POS_W-1], pos_x} - {anchor_x[lps_pkg::POS_W-1], anchor_x};
  assign dy  = {pos_y[lps_pkg::POS_W-1], pos_y} - {anchor_y[lps_pkg::POS_W-1], anchor_y};
  // Magnitude fits unsigned in the same width, including the most negative case.
  assign adx = dx[lps_pkg::DIFF_W-1] ? (~dx + 1'b1) : dx;
  assign ady = dy[lps_pkg::DIFF_W-1] ? (~dy + 1'b1) : dy;
  assign sqx = adx * adx;
  assign sqy = ady * ady;
  assign dist2 = {1'b0, sqx} + {1'b0, sqy};
  assign near_pos = dist2 <= {{(lps_pkg::SUM_W - lps_pkg::LIM_W){1'b0}}, cfg.dist_sq};

  // Wrap to signed range; half a turn counts as its full magnitude.
  assign dh  = heading - anchor_heading;
  assign adh = dh[lps_pkg::HEAD_W-1] ? ({1'b1, {lps_pkg::HEAD_W{1'b0}}} - {1'b0, dh})
                                     : {1'b0, dh};
  assign near_head = adh <= {1'b0, cfg.max_heading_diff};

  assign hit = near_pos && near_head;

endmodule

>>> rtl/core/lps_checker.sv
// Port-level checks for the localization phase supervisor, bound to the top.
// Depends on lps_pkg and localization_phase_supervisor.
module lps_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        status_valid,
  input logic                        status_ready,
  input logic [lps_pkg::CODE_W-1:0]  phase,
  input logic [lps_pkg::CODE_W-1:0]  action,
  input logic                        pose_accepted,
  input logic [lps_pkg::CNT_W-1:0]   consistent_count,
  input logic [lps_pkg::CNT_W-1:0]   failure_count
);

  // Accepted start pose lands in waiting with a fresh failure count.
  a_accept_wait: assert property (@(posedge clk) disable iff (rst)
    status_valid && pose_accepted |->
      phase == lps_pkg::PHASE_WAIT && failure_count == '0 && consistent_count != '0)
    else $error("accepted pose without entering waiting phase");

  // Relocalization leaves everything cleared and searching.
  a_enable_clear: assert property (@(posedge clk) disable iff (rst)
    status_valid && action == lps_pkg::ACT_ENABLE |->
      phase == lps_pkg::PHASE_SEARCH && failure_count == '0 && consistent_count == '0)
    else $error("enable command without cleared search state");

  // Disable is only issued on the move into tracking.
  a_disable_track: assert property (@(posedge clk) disable iff (rst)
    status_valid && action == lps_pkg::ACT_DISABLE |->
      phase == lps_pkg::PHASE_TRACK && failure_count == '0 && !pose_accepted)
    else $error("disable command outside tracking entry");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    status_valid && !status_ready |=>
      status_valid && $stable(phase) && $stable(action) && $stable(pose_accepted) &&
      $stable(consistent_count) && $stable(failure_count))
    else $error("stalled result changed");

endmodule

bind localization_phase_supervisor lps_checker u_lps_checker (
  .clk              (clk),
  .rst              (rst),
  .status_valid     (status.valid),
  .status_ready     (status.ready),
  .phase            (status.phase),
  .action           (status.action),
  .pose_accepted    (status.pose_accepted),
  .consistent_count (status.consistent_count),
  .failure_count    (status.failure_count)
);

>>> tb/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for localization_phase_supervisor: a directed table, then random
// event streams under changing idle patterns, with every status checked against its row or a predictor.
// Depends on lps_pkg and the lps_in_if / lps_out_if channel interfaces of the RTL.
module tb;

  typedef logic [lps_pkg::FUNC_W-1:0]        func_t;
  typedef logic signed [lps_pkg::POS_W-1:0]  pos_t;
  typedef logic [lps_pkg::HEAD_W-1:0]        head_t;
  typedef logic [lps_pkg::CNT_W-1:0]         cnt_t;
  typedef logic [lps_pkg::DIST_W-1:0]        dist_t;
  typedef logic [lps_pkg::CODE_W-1:0]        code_t;

  // Event kind that the block ignores; it lies outside the three defined kinds.
  localparam func_t FUNC_UNUSED = 2'd3;

  localparam int DIR_ROWS        = 26;
  localparam int DIR_SPLIT       = 22;   // rows from here on run with the second setting
  localparam int RAND_PHASES     = 6;
  localparam int EVENTS_PER_PHASE = 265;
  localparam int LATENCY_CYCLES  = 4;
  localparam int HOLD_OFF_CYCLES = 150;
  localparam int STALL_LIMIT     = 1000;

  typedef struct packed {
    func_t  func;
    pos_t   pos_x;
    pos_t   pos_y;
    head_t  heading;
    logic   pose_valid;
    logic   match_accepted;
  } pose_event_t;

  typedef struct packed {
    code_t phase;
    code_t action;
    logic  pose_accepted;
    cnt_t  consistent_count;
    cnt_t  failure_count;
  } status_t;

  typedef struct packed {
    pose_event_t ev;
    logic        typed;   // 1: check against the status written in the row
    status_t     want;
  } directed_row_t;

  typedef struct packed {
    cnt_t  target;
    dist_t max_dist;
    head_t max_head;
    cnt_t  fail_limit;
  } supervisor_cfg_t;

  logic                       clk;
  logic                       rst;
  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [lps_pkg::ADDR_W-1:0] paddr;
  logic [lps_pkg::DATA_W-1:0] pwdata;
  logic [lps_pkg::DATA_W-1:0] prdata;
  logic                       pready;

  lps_in_if  pose_ch();
  lps_out_if stat_ch();

  localization_phase_supervisor dut (
    .clk     (clk),
    .rst     (rst),
    .pose    (pose_ch),
    .status  (stat_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Predicted supervisor state and register copy.
  code_t           sv_phase;
  logic            sv_anchor_valid;
  pos_t            sv_anchor_x;
  pos_t            sv_anchor_y;
  head_t           sv_anchor_heading;
  cnt_t            sv_consistent;
  cnt_t            sv_failures;
  supervisor_cfg_t sv_cfg;

  status_t status_q[$];       // statuses still owed by the block, oldest first
  int      errors;
  int      src_idle_pct;
  int      snk_idle_pct;
  int      hold_off_req;      // bumped by the stimulus, followed by the sink process
  int      hold_off_done;
  int      quiet_cycles;

  // Directed table. Typed rows: after reset, at the thresholds, and at the
  // phase changes. Untyped rows lean on the predictor.
  directed_row_t dir_tab [0:DIR_ROWS-1] = '{
    // match results and an unusable pose while searching: all ignored
    '{'{lps_pkg::FUNC_MATCH, 24'h000000, 24'h000000, 16'h0000, 1'b0, 1'b1}, 1'b1,
      '{lps_pkg::PHASE_SEARCH, lps_pkg::ACT_NONE, 1'b0, 8'd0, 8'd0}},
    '{'{lps_pkg::FUNC_MATCH, 24'h000000, 24'h000000, 16'h0000, 1'b0, 1'b0}, 1'b1,
      '{lps_pkg::PHASE_SEARCH, lps_pkg::ACT_NONE, 1'b0, 8'd0, 8'd0}},
    '{'{lps_pkg::FUNC_POSE, 24'h7FFFFF, 24'h800000, 16'hFFFF, 1'b0, 1'b1}, 1'b1,
      '{lps_pkg::PHASE_SEARCH, lps_pkg::ACT_NONE, 1'b0, 8'd0, 8'd0}},
    // first anchor, then a pose exactly on both limits
    '{'{lps_pkg::FUNC_POSE, 24'h000000, 24'h000000, 16'h0000, 1'b1, 1'b0}, 1'b1,
      '{lps_pkg::PHASE_SEARCH, lps_pkg::ACT_NONE, 1'b0, 8'd1, 8'd0}},
    '{'{lps_pkg::FUNC_POSE, 24'h000100, 24'h000000, 16'd1820, 1'b1, 1'b0}, 1'b1,
      '{lps_pkg::PHASE_SEARCH, lps_pkg::ACT_NONE, 1'b0, 8'd2, 8'd0}},
    // one step too far: new anchor
    '{'{lps_pkg::FUNC_POSE, 24'h000101, 24'h000000, 16'h0000, 1'b1, 1'b0}, 1'b1,
      '{lps_pkg::PHASE_SEARCH, lps_pkg::ACT_NONE, 1'b0, 8'd1, 8'd0}},
    // heading wraps below zero, exactly at the limit
    '{'{lps_pkg::FUNC_POSE, 24'h000101, 24'hFFFF00, 16'd63716, 1'b1, 1'b0}, 1'b1,
      '{lps_pkg::PHASE_SEARCH, lps_pkg::ACT_NONE, 1'b0, 8'd2, 8'd0}},
    '{'{lps_pkg::FUNC_POSE, 24'h000101, 24'h000000, 16'd63715, 1'b1, 1'b0}, 1'b1,
      '{lps_pkg::PHASE_SEARCH, lps_pkg::ACT_NONE, 1'b0, 8'd1, 8'd0}},
    '{'{FUNC_UNUSED, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF, 1'b1, 1'b1}, 1'b1,
      '{lps_pkg::PHASE_SEARCH, lps_pkg::ACT_NONE, 1'b0, 8'd1, 8'd0}},
    '{'{lps_pkg::FUNC_POSE, 24'h000101, 24'h000000, 16'd63715, 1'b1, 1'b1}, 1'b0, '0},
    // target reached: accept the pose
    '{'{lps_pkg::FUNC_POSE, 24'h000101, 24'h000000, 16'd63715, 1'b1, 1'b0}, 1'b1,
      '{lps_pkg::PHASE_WAIT, lps_pkg::ACT_NONE, 1'b1, 8'd3, 8'd0}},
    '{'{lps_pkg::FUNC_POSE, 24'h000101, 24'h000000, 16'd63715, 1'b1, 1'b0}, 1'b1,
      '{lps_pkg::PHASE_WAIT, lps_pkg::ACT_NONE, 1'b0, 8'd3, 8'd0}},
    '{'{lps_pkg::FUNC_MATCH, 24'h000000, 24'h000000, 16'h0000, 1'b1, 1'b0}, 1'b0, '0},
    '{'{lps_pkg::FUNC_MATCH, 24'h000000, 24'h000000, 16'h0000, 1'b1, 1'b0}, 1'b0, '0},
    '{'{lps_pkg::FUNC_MATCH, 24'h000000, 24'h000000, 16'h0000, 1'b0, 1'b1}, 1'b1,
      '{lps_pkg::PHASE_TRACK, lps_pkg::ACT_DISABLE, 1'b0, 8'd3, 8'd0}},
    '{'{lps_pkg::FUNC_MATCH, 24'h000000, 24'h000000, 16'h0000, 1'b0, 1'b1}, 1'b0, '0},
    '{'{lps_pkg::FUNC_MATCH, 24'h000000, 24'h000000, 16'h0000, 1'b0, 1'b0}, 1'b0, '0},
    '{'{lps_pkg::FUNC_MATCH, 24'h000000, 24'h000000, 16'h0000, 1'b0, 1'b0}, 1'b0, '0},
    // third rejection in a row: relocalize
    '{'{lps_pkg::FUNC_MATCH, 24'h000000, 24'h000000, 16'h0000, 1'b0, 1'b0}, 1'b1,
      '{lps_pkg::PHASE_SEARCH, lps_pkg::ACT_ENABLE, 1'b0, 8'd0, 8'd0}},
    '{'{lps_pkg::FUNC_POSE, 24'h800000, 24'h7FFFFF, 16'hFFFF, 1'b1, 1'b0}, 1'b1,
      '{lps_pkg::PHASE_SEARCH, lps_pkg::ACT_NONE, 1'b0, 8'd1, 8'd0}},
    '{'{lps_pkg::FUNC_POSE, 24'h7FFFFF, 24'h800000, 16'h7FFF, 1'b1, 1'b0}, 1'b1,
      '{lps_pkg::PHASE_SEARCH, lps_pkg::ACT_NONE, 1'b0, 8'd1, 8'd0}},
    '{'{lps_pkg::FUNC_FORCE, 24'h000000, 24'h000000, 16'h0000, 1'b0, 1'b0}, 1'b1,
      '{lps_pkg::PHASE_SEARCH, lps_pkg::ACT_NONE, 1'b0, 8'd0, 8'd0}},
    // second setting: target 2, widest distance, heading limit just under half a turn
    '{'{lps_pkg::FUNC_POSE, 24'h000000, 24'h000000, 16'h0000, 1'b1, 1'b0}, 1'b1,
      '{lps_pkg::PHASE_SEARCH, lps_pkg::ACT_NONE, 1'b0, 8'd1, 8'd0}},
    '{'{lps_pkg::FUNC_POSE, 24'h7FFFFF, 24'h000000, 16'h8000, 1'b1, 1'b0}, 1'b1,
      '{lps_pkg::PHASE_SEARCH, lps_pkg::ACT_NONE, 1'b0, 8'd1, 8'd0}},
    '{'{lps_pkg::FUNC_POSE, 24'h000000, 24'h000000, 16'hFFFF, 1'b1, 1'b0}, 1'b1,
      '{lps_pkg::PHASE_WAIT, lps_pkg::ACT_NONE, 1'b1, 8'd2, 8'd0}},
    '{'{lps_pkg::FUNC_MATCH, 24'h000000, 24'h000000, 16'h0000, 1'b0, 1'b0}, 1'b1,
      '{lps_pkg::PHASE_SEARCH, lps_pkg::ACT_ENABLE, 1'b0, 8'd0, 8'd0}}
  };

  // Register settings for the random phases; the last two are drawn at run time.
  supervisor_cfg_t cfg_plan [0:RAND_PHASES-1] = '{
    '{8'd1,   23'd0,       16'd0,     8'd1},
    '{8'd4,   23'd300,     16'd2000,  8'd2},
    '{8'd255, 23'd8388607, 16'd32768, 8'd255},
    '{8'd6,   23'd1000,    16'd500,   8'd4},
    '0,
    '0
  };

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Advance the predicted state by one event and return the status it yields.
  function automatic status_t step_supervisor(pose_event_t ev);
    status_t res;
    longint  dx;
    longint  dy;
    longint  dist_sq;
    longint  lim_sq;
    head_t   dh;
    int      abs_dh;
    logic    near;
    res = '0;
    res.action = lps_pkg::ACT_NONE;
    case (ev.func)
      lps_pkg::FUNC_POSE: begin
        if (sv_phase == lps_pkg::PHASE_SEARCH && ev.pose_valid) begin
          dx      = longint'($signed(ev.pos_x)) - longint'(sv_anchor_x);
          dy      = longint'($signed(ev.pos_y)) - longint'(sv_anchor_y);
          dist_sq = dx * dx + dy * dy;
          lim_sq  = longint'(sv_cfg.max_dist) * longint'(sv_cfg.max_dist);
          // Wrap the heading difference to a signed half turn, then take its size.
          dh      = ev.heading - sv_anchor_heading;
          abs_dh  = dh[lps_pkg::HEAD_W-1] ? 65536 - int'(dh) : int'(dh);
          near    = (dist_sq <= lim_sq) && (abs_dh <= int'(sv_cfg.max_head));
          if (sv_anchor_valid && near) begin
            if (sv_consistent != 8'hFF) sv_consistent++;
          end else begin
            sv_anchor_valid   = 1'b1;
            sv_anchor_x       = ev.pos_x;
            sv_anchor_y       = ev.pos_y;
            sv_anchor_heading = ev.heading;
            sv_consistent     = 8'd1;
          end
          if (sv_consistent >= sv_cfg.target) begin
            sv_phase          = lps_pkg::PHASE_WAIT;
            sv_failures       = '0;
            res.pose_accepted = 1'b1;
          end
        end
      end
      lps_pkg::FUNC_MATCH: begin
        if (sv_phase != lps_pkg::PHASE_SEARCH) begin
          if (ev.match_accepted) begin
            sv_failures = '0;
            if (sv_phase == lps_pkg::PHASE_WAIT) begin
              sv_phase   = lps_pkg::PHASE_TRACK;
              res.action = lps_pkg::ACT_DISABLE;
            end
          end else begin
            if (sv_failures != 8'hFF) sv_failures++;
            if (sv_failures >= sv_cfg.fail_limit) begin
              sv_phase        = lps_pkg::PHASE_SEARCH;
              sv_failures     = '0;
              sv_anchor_valid = 1'b0;
              sv_consistent   = '0;
              res.action      = lps_pkg::ACT_ENABLE;
            end
          end
        end
      end
      lps_pkg::FUNC_FORCE: begin
        sv_phase        = lps_pkg::PHASE_SEARCH;
        sv_failures     = '0;
        sv_anchor_valid = 1'b0;
        sv_consistent   = '0;
      end
      default: begin
      end
    endcase
    res.phase            = sv_phase;
    res.consistent_count = sv_consistent;
    res.failure_count    = sv_failures;
    return res;
  endfunction

  // Offer one event, idling first at the sender's rate. Called at a falling edge,
  // returns at a falling edge. On acceptance, queue either the typed status or
  // the predicted one; the predictor runs in both cases to keep its state.
  task automatic offer_event(pose_event_t ev, logic typed, status_t want);
    status_t predicted;
    while ($urandom_range(99) < src_idle_pct) begin
      pose_ch.valid <= 1'b0;
      @(negedge clk);
    end
    pose_ch.valid          <= 1'b1;
    pose_ch.func           <= ev.func;
    pose_ch.pos_x          <= ev.pos_x;
    pose_ch.pos_y          <= ev.pos_y;
    pose_ch.heading        <= ev.heading;
    pose_ch.pose_valid     <= ev.pose_valid;
    pose_ch.match_accepted <= ev.match_accepted;
    @(posedge clk);
    while (!pose_ch.ready) @(posedge clk);
    predicted = step_supervisor(ev);
    status_q.push_back(typed ? want : predicted);
    @(negedge clk);
  endtask

  // Register write in setup and access phases; the block takes it at the access-phase edge.
  task automatic write_register(logic [1:0] idx, logic [lps_pkg::DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      lps_pkg::REG_POSE_TARGET:  sv_cfg.target     = value[lps_pkg::CNT_W-1:0];
      lps_pkg::REG_MAX_DISTANCE: sv_cfg.max_dist   = value[lps_pkg::DIST_W-1:0];
      lps_pkg::REG_MAX_HEADING:  sv_cfg.max_head   = value[lps_pkg::HEAD_W-1:0];
      lps_pkg::REG_FAIL_LIMIT:   sv_cfg.fail_limit = value[lps_pkg::CNT_W-1:0];
      default: begin
      end
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  // Drop valid and wait until every owed status has come back, then for LATENCY_CYCLES more.
  task automatic drain_status();
    pose_ch.valid <= 1'b0;
    while (status_q.size() != 0) @(negedge clk);
    repeat (LATENCY_CYCLES) @(negedge clk);
  endtask

  // Receiver: random back-pressure, or a long hold-off when the stimulus asks for one.
  initial begin
    stat_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_done != hold_off_req) begin
        stat_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        hold_off_done = hold_off_req;
      end else begin
        stat_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  // Check every status transaction against the oldest owed status.
  always @(posedge clk) begin
    status_t got;
    status_t want;
    if (!rst && stat_ch.valid && stat_ch.ready) begin
      got = '{stat_ch.phase, stat_ch.action, stat_ch.pose_accepted,
              stat_ch.consistent_count, stat_ch.failure_count};
      if (status_q.size() == 0) begin
        errors++;
        $display("%0t: status with none owed: phase %0d action %0d acc %0b cons %0d fail %0d",
                 $realtime, got.phase, got.action, got.pose_accepted,
                 got.consistent_count, got.failure_count);
      end else begin
        want = status_q.pop_front();
        if (got !== want) begin
          errors++;
          $display("%0t: mismatch: expected phase %0d action %0d acc %0b cons %0d fail %0d",
                   $realtime, want.phase, want.action, want.pose_accepted,
                   want.consistent_count, want.failure_count);
          $display("%0t:           actual   phase %0d action %0d acc %0b cons %0d fail %0d",
                   $realtime, got.phase, got.action, got.pose_accepted,
                   got.consistent_count, got.failure_count);
        end
      end
    end
  end

  // Watchdog: end the run when neither channel moves a transaction for too long.
  always @(posedge clk) begin
    if (rst || (pose_ch.valid && pose_ch.ready) || (stat_ch.valid && stat_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles, %0d statuses owed",
               $realtime, quiet_cycles, status_q.size());
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int              i;
    int              p;
    int              useful;
    int              draw;
    int              half_d;
    int              half_h;
    logic            noise;
    pos_t            cx;
    pos_t            cy;
    head_t           ch;
    pose_event_t     ev;
    supervisor_cfg_t cfg;

    // Hold every input at a known value from time zero.
    rst                    = 1'b1;
    psel                   = 1'b0;
    penable                = 1'b0;
    pwrite                 = 1'b0;
    paddr                  = '0;
    pwdata                 = '0;
    pose_ch.valid          = 1'b0;
    pose_ch.func           = lps_pkg::FUNC_POSE;
    pose_ch.pos_x          = '0;
    pose_ch.pos_y          = '0;
    pose_ch.heading        = '0;
    pose_ch.pose_valid     = 1'b0;
    pose_ch.match_accepted = 1'b0;
    hold_off_req           = 0;
    src_idle_pct           = 29;
    snk_idle_pct           = 83;
    cx                     = '0;
    cy                     = '0;
    ch                     = '0;

    // Predictor starts from the reset state and reset register values.
    sv_phase          = lps_pkg::PHASE_SEARCH;
    sv_anchor_valid   = 1'b0;
    sv_anchor_x       = '0;
    sv_anchor_y       = '0;
    sv_anchor_heading = '0;
    sv_consistent     = '0;
    sv_failures       = '0;
    sv_cfg            = '{lps_pkg::RST_POSE_TARGET, lps_pkg::RST_MAX_DISTANCE,
                          lps_pkg::RST_MAX_HEADING, lps_pkg::RST_FAIL_LIMIT};

    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed table, first with the reset registers, then with a second setting.
    for (i = 0; i < DIR_SPLIT; i++)
      offer_event(dir_tab[i].ev, dir_tab[i].typed, dir_tab[i].want);
    drain_status();
    write_register(lps_pkg::REG_POSE_TARGET, 32'd2);
    write_register(lps_pkg::REG_MAX_DISTANCE, 32'd8388607);
    write_register(lps_pkg::REG_MAX_HEADING, 32'd32767);
    write_register(lps_pkg::REG_FAIL_LIMIT, 32'd1);
    for (i = DIR_SPLIT; i < DIR_ROWS; i++)
      offer_event(dir_tab[i].ev, dir_tab[i].typed, dir_tab[i].want);
    drain_status();

    // Random phases: receiver-idle pattern first, then sender-idle, then none.
    for (p = 0; p < RAND_PHASES; p++) begin
      src_idle_pct = (p < 2) ? 29 : (p < 4) ? 83 : 0;
      snk_idle_pct = (p < 2) ? 83 : (p < 4) ? 29 : 0;
      cfg = cfg_plan[p];
      if (p >= 4) begin
        cfg.target     = cnt_t'($urandom_range(8, 1));
        cfg.max_dist   = dist_t'($urandom_range(4095));
        cfg.max_head   = head_t'($urandom_range(32768));
        cfg.fail_limit = cnt_t'($urandom_range(6, 1));
      end
      write_register(lps_pkg::REG_POSE_TARGET, 32'(cfg.target));
      write_register(lps_pkg::REG_MAX_DISTANCE, 32'(cfg.max_dist));
      write_register(lps_pkg::REG_MAX_HEADING, 32'(cfg.max_head));
      write_register(lps_pkg::REG_FAIL_LIMIT, 32'(cfg.fail_limit));

      useful = 0;
      while (useful < EVENTS_PER_PHASE) begin
        ev    = '0;
        noise = 1'b0;
        draw  = $urandom_range(99);
        // A high target needs long unbroken runs: drop force and noise then.
        if (sv_cfg.target > 16) draw = 16 + $urandom_range(83);
        if (draw < 4) begin
          ev.func = lps_pkg::FUNC_FORCE;
        end else if (draw < 16) begin
          // Noise: any defined kind, any content.
          noise = 1'b1;
          ev.func = func_t'($urandom_range(2));
        end
        if (draw < 16) begin
          ev.pos_x          = pos_t'($urandom);
          ev.pos_y          = pos_t'($urandom);
          ev.heading        = head_t'($urandom);
          ev.pose_valid     = 1'($urandom);
          ev.match_accepted = 1'($urandom);
        end else if (sv_phase == lps_pkg::PHASE_SEARCH) begin
          // Poses scattered around a cluster center, mostly within the limits.
          if ($urandom_range((sv_cfg.target > 16) ? 511 : 9) == 0) begin
            cx = pos_t'($urandom);
            cy = pos_t'($urandom);
            ch = head_t'($urandom);
          end
          half_d = int'(sv_cfg.max_dist) / (($urandom_range(3) == 0) ? 1 : 2);
          half_h = int'(sv_cfg.max_head) / (($urandom_range(3) == 0) ? 1 : 2);
          ev.func           = lps_pkg::FUNC_POSE;
          ev.pos_x          = pos_t'(cx + ($urandom_range(2 * half_d) - half_d));
          ev.pos_y          = pos_t'(cy + ($urandom_range(2 * half_d) - half_d));
          ev.heading        = head_t'(ch + ($urandom_range(2 * half_h) - half_h));
          ev.pose_valid     = 1'b1;
          ev.match_accepted = 1'($urandom);
        end else begin
          // Waiting or tracking: fine match results, slightly more rejected than accepted.
          ev.func           = lps_pkg::FUNC_MATCH;
          ev.pos_x          = pos_t'($urandom);
          ev.pos_y          = pos_t'($urandom);
          ev.heading        = head_t'($urandom);
          ev.pose_valid     = 1'($urandom);
          ev.match_accepted = ($urandom_range(99) < 45);
        end
        // Stall the receiver for a long stretch while events keep coming.
        if (p == RAND_PHASES - 1 && useful == 100 && !noise) hold_off_req++;
        offer_event(ev, 1'b0, '0);
        if (!noise) useful++;
      end
      drain_status();
    end

    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
